[rtl/prvu_pkg.sv]
`default_nettype none

package prvu_pkg;

    // Number format and field widths
    localparam int FRACTION_BITS = 24;
    localparam int RANK_WIDTH    = 32;
    localparam int SUM_WIDTH     = 40;
    localparam int DEGREE_WIDTH  = 24;
    localparam int TELE_WIDTH    = FRACTION_BITS + 1;

    // The blend product is formed from a low and a high slice of the sum
    localparam int SPLIT_WIDTH   = 32;
    localparam int UP_SHIFT      = SPLIT_WIDTH - FRACTION_BITS;
    localparam int PLO_WIDTH     = SPLIT_WIDTH + TELE_WIDTH;
    localparam int PHI_WIDTH     = SUM_WIDTH - SPLIT_WIDTH + TELE_WIDTH;
    localparam int TOTAL_WIDTH   = RANK_WIDTH + 3;

    // Divider step counter
    localparam int DIV_CNT_WIDTH = $clog2(RANK_WIDTH);

    localparam logic [TELE_WIDTH-1:0]  FIXED_ONE     = TELE_WIDTH'(1) << FRACTION_BITS;
    localparam logic [TELE_WIDTH-1:0]  TELEPORT_RST  = TELE_WIDTH'(2516582);
    localparam logic [RANK_WIDTH-1:0]  RANK_MAX      = '1;
    localparam logic [SUM_WIDTH-1:0]   SUM_MAX       = '1;
    localparam logic [PHI_WIDTH-1:0]   PHI_LIMIT     = PHI_WIDTH'(RANK_MAX >> UP_SHIFT);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);

    // One closed vertex, handed from the accumulator to the update engine
    typedef struct packed {
        logic                     initial_pass;
        logic [RANK_WIDTH-1:0]    previous_rank;
        logic [DEGREE_WIDTH-1:0]  out_degree;
        logic                     sum_overflowed;
        logic [SUM_WIDTH-1:0]     contribution_sum;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

[rtl/prvu_front.sv]
`default_nettype none

module prvu_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [prvu_pkg::RANK_WIDTH-1:0]    edge_contribution,
    input  wire logic                               contribution_valid,
    input  wire logic                               last_of_vertex,
    input  wire logic [prvu_pkg::DEGREE_WIDTH-1:0]  out_degree,
    input  wire logic [prvu_pkg::RANK_WIDTH-1:0]    previous_rank,
    input  wire logic                               initial_pass,
    output logic                                    q_push,
    output prvu_pkg::job_t                          q_job,
    input  wire logic                               q_full
);

    logic [prvu_pkg::SUM_WIDTH-1:0] sum_reg, sum_next;
    logic                           ovf_reg, ovf_next;
    logic [prvu_pkg::SUM_WIDTH:0]   sum_wide;
    logic                           accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Saturating accumulate of the running sum
    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (prvu_pkg::SUM_WIDTH + 1)'(edge_contribution);
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (contribution_valid && !initial_pass)
        begin
            if (sum_wide[prvu_pkg::SUM_WIDTH])
            begin
                sum_next = prvu_pkg::SUM_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                sum_next = sum_wide[prvu_pkg::SUM_WIDTH-1:0];
            end
        end
    end

    // Close the vertex on its last item
    assign q_push                 = accept && last_of_vertex;
    assign q_job.initial_pass     = initial_pass;
    assign q_job.previous_rank    = previous_rank;
    assign q_job.out_degree       = out_degree;
    assign q_job.sum_overflowed   = ovf_next;
    assign q_job.contribution_sum = sum_next;

    // Hold the sum between items, clear it after each vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_of_vertex)
            begin
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                sum_reg <= sum_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/prvu_queue.sv]
`default_nettype none

module prvu_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire prvu_pkg::job_t  push_data,
    output logic                 full,
    input  wire logic            pop,
    output prvu_pkg::job_t       pop_data,
    output logic                 empty
);

    prvu_pkg::job_t                      mem [prvu_pkg::QUEUE_DEPTH];
    logic [prvu_pkg::QPTR_WIDTH-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [prvu_pkg::QPTR_WIDTH:0]       count_reg;
    logic                                do_push, do_pop;

    assign full     = (count_reg == (prvu_pkg::QPTR_WIDTH + 1)'(prvu_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/prvu_back.sv]
`default_nettype none

module prvu_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [prvu_pkg::TELE_WIDTH-1:0]    teleport,
    input  wire prvu_pkg::job_t                     q_job,
    input  wire logic                               q_empty,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [prvu_pkg::RANK_WIDTH-1:0]         new_rank,
    output logic [prvu_pkg::RANK_WIDTH-1:0]         edge_share,
    output logic [prvu_pkg::RANK_WIDTH-1:0]         rank_change,
    output logic                                    saturated
);

    prvu_pkg::back_state_t state_reg, state_next;

    prvu_pkg::job_t                            job_reg;
    logic [prvu_pkg::PLO_WIDTH-1:0]            plo_reg;
    logic [prvu_pkg::PHI_WIDTH-1:0]            phi_reg;
    logic [prvu_pkg::RANK_WIDTH-1:0]           rank_reg, change_reg, share_reg;
    logic                                      sat_reg;
    logic [prvu_pkg::RANK_WIDTH-1:0]           quo_reg, quo_next;
    logic [prvu_pkg::DEGREE_WIDTH-1:0]         rem_reg, rem_next;
    logic [prvu_pkg::DIV_CNT_WIDTH-1:0]        cnt_reg;

    logic [prvu_pkg::TELE_WIDTH-1:0]           t_clamped, one_minus_t;
    logic [prvu_pkg::TOTAL_WIDTH-1:0]          total;
    logic                                      hi_ovf, total_ovf;
    logic [prvu_pkg::RANK_WIDTH-1:0]           rank_calc, change_calc;
    logic                                      sat_calc;
    logic [prvu_pkg::DEGREE_WIDTH:0]           trial, trial_diff;
    logic                                      trial_ge, div_last;

    // Teleport above one counts as exactly one
    assign t_clamped   = (teleport > prvu_pkg::FIXED_ONE) ? prvu_pkg::FIXED_ONE : teleport;
    assign one_minus_t = prvu_pkg::FIXED_ONE - t_clamped;

    // Blend: t + (1 - t) * sum, with clamp to the rank range; just t on the initial pass; also the rank change
    always_comb
    begin
        hi_ovf    = (phi_reg > prvu_pkg::PHI_LIMIT);
        total     = (prvu_pkg::TOTAL_WIDTH'(phi_reg) << prvu_pkg::UP_SHIFT)
                  + prvu_pkg::TOTAL_WIDTH'(plo_reg >> prvu_pkg::FRACTION_BITS)
                  + prvu_pkg::TOTAL_WIDTH'(t_clamped);
        total_ovf = (total > prvu_pkg::TOTAL_WIDTH'(prvu_pkg::RANK_MAX));
        if (job_reg.initial_pass)
        begin
            rank_calc = prvu_pkg::RANK_WIDTH'(t_clamped);
            sat_calc  = 1'b0;
        end
        else if (hi_ovf || total_ovf)
        begin
            rank_calc = prvu_pkg::RANK_MAX;
            sat_calc  = 1'b1;
        end
        else
        begin
            rank_calc = total[prvu_pkg::RANK_WIDTH-1:0];
            sat_calc  = job_reg.sum_overflowed;
        end
        if (job_reg.initial_pass)
        begin
            change_calc = '0;
        end
        else if (rank_calc >= job_reg.previous_rank)
        begin
            change_calc = rank_calc - job_reg.previous_rank;
        end
        else
        begin
            change_calc = job_reg.previous_rank - rank_calc;
        end
    end

    // One restoring division step per cycle
    always_comb
    begin
        trial      = {rem_reg, quo_reg[prvu_pkg::RANK_WIDTH-1]};
        trial_diff = trial - {1'b0, job_reg.out_degree};
        trial_ge   = (trial >= {1'b0, job_reg.out_degree});
        rem_next   = trial_ge ? trial_diff[prvu_pkg::DEGREE_WIDTH-1:0]
                              : trial[prvu_pkg::DEGREE_WIDTH-1:0];
        quo_next   = {quo_reg[prvu_pkg::RANK_WIDTH-2:0], trial_ge};
        div_last   = (cnt_reg == prvu_pkg::DIV_CNT_WIDTH'(prvu_pkg::RANK_WIDTH - 1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            prvu_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = prvu_pkg::BK_MUL;
                end
            end
            prvu_pkg::BK_MUL: state_next = prvu_pkg::BK_ADD;
            prvu_pkg::BK_ADD: state_next = prvu_pkg::BK_DIV;
            prvu_pkg::BK_DIV:
            begin
                if (div_last)
                begin
                    state_next = prvu_pkg::BK_OUT;
                end
            end
            prvu_pkg::BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = prvu_pkg::BK_IDLE;
                end
            end
            default: state_next = prvu_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prvu_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            prvu_pkg::BK_IDLE:
            begin
                job_reg <= q_job;
            end
            prvu_pkg::BK_MUL:
            begin
                plo_reg <= prvu_pkg::PLO_WIDTH'(
                               job_reg.contribution_sum[prvu_pkg::SPLIT_WIDTH-1:0])
                           * prvu_pkg::PLO_WIDTH'(one_minus_t);
                phi_reg <= prvu_pkg::PHI_WIDTH'(
                               job_reg.contribution_sum[prvu_pkg::SUM_WIDTH-1:
                                                        prvu_pkg::SPLIT_WIDTH])
                           * prvu_pkg::PHI_WIDTH'(one_minus_t);
            end
            prvu_pkg::BK_ADD:
            begin
                rank_reg   <= rank_calc;
                change_reg <= change_calc;
                sat_reg    <= sat_calc;
                rem_reg    <= '0;
                cnt_reg    <= '0;
                quo_reg    <= job_reg.initial_pass
                              ? prvu_pkg::RANK_WIDTH'(prvu_pkg::FIXED_ONE) : rank_calc;
            end
            prvu_pkg::BK_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (div_last)
                begin
                    share_reg <= (job_reg.out_degree == '0) ? '0 : quo_next;
                end
            end
            prvu_pkg::BK_OUT:
            begin
                share_reg <= share_reg;
            end
            default:
            begin
                share_reg <= share_reg;
            end
        endcase
    end

    assign out_valid   = (state_reg == prvu_pkg::BK_OUT);
    assign new_rank    = rank_reg;
    assign edge_share  = share_reg;
    assign rank_change = change_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

[rtl/pagerank_vertex_update.sv]
// PageRank vertex update, un-normalized, unsigned Q8.24. In-edge contributions
// stream in one request per cycle while the queue is not full and are summed
// in a saturating 40-bit accumulator; the request with tlast closes the vertex
// and queues it (two entries deep) for the update engine, which steps through
// a fetch, the 40x25 blend multiply in two slices, add, clamp and rank change,
// a one-bit-per-step divider for the per-edge share, and an output state that
// presents the result until it is taken. The teleport register resets to about
// 0.15 and must only be written while the block is idle.
`default_nettype none

module pagerank_vertex_update (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [24:0]   cfg_wr_data,    // teleport_probability, Q1.24
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] edge_contribution, [55:32] out_degree, [87:56] previous_rank
    input  wire logic [87:0]   s_axis_tdata,
    // [0] contribution_valid, [1] initial_pass
    input  wire logic [1:0]    s_axis_tuser,
    input  wire logic          s_axis_tlast,   // last_of_vertex
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [31:0] new_rank, [63:32] edge_share, [95:64] rank_change
    output logic [95:0]        m_axis_tdata,
    output logic [0:0]         m_axis_tuser    // [0] saturated
);

    logic [prvu_pkg::TELE_WIDTH-1:0] teleport_reg;
    logic                            q_push, q_full, q_pop, q_empty;
    prvu_pkg::job_t                  q_in, q_out;

    // Teleport probability register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            teleport_reg <= prvu_pkg::TELEPORT_RST;
        end
        else if (cfg_wr_en)
        begin
            teleport_reg <= cfg_wr_data;
        end
    end

    prvu_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .edge_contribution  (s_axis_tdata[31:0]),
        .contribution_valid (s_axis_tuser[0]),
        .last_of_vertex     (s_axis_tlast),
        .out_degree         (s_axis_tdata[55:32]),
        .previous_rank      (s_axis_tdata[87:56]),
        .initial_pass       (s_axis_tuser[1]),
        .q_push             (q_push),
        .q_job              (q_in),
        .q_full             (q_full)
    );

    prvu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    prvu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .teleport    (teleport_reg),
        .q_job       (q_out),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .new_rank    (m_axis_tdata[31:0]),
        .edge_share  (m_axis_tdata[63:32]),
        .rank_change (m_axis_tdata[95:64]),
        .saturated   (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

[rtl/prvu_checker.sv]
`default_nettype none

module prvu_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire logic [95:0]   m_axis_tdata,
    input  wire logic [0:0]    m_axis_tuser
);

    // Hold a stalled result request
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result request dropped");

    property p_out_stable;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser);
    endproperty
    a_out_stable: assert property (p_out_stable) else $error("stalled result changed");

    // Share never exceeds the rank, except the initial 1/degree share
    property p_share_bound;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] <= m_axis_tdata[31:0])
                       || (m_axis_tdata[63:32] <= 32'd16777216);
    endproperty
    a_share_bound: assert property (p_share_bound) else $error("edge share above rank");

    // One result per vertex: after a taken result, valid stays low through the idle and multiply states
    property p_result_spacing;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid ##1 !m_axis_tvalid;
    endproperty
    a_result_spacing: assert property (p_result_spacing) else $error("results too close");

endmodule

bind pagerank_vertex_update prvu_checker u_prvu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
